[hdl/fdc_pkg.sv]
// ----------------------------------------------------------------------------
// fdc_pkg
// Types and fixed constants shared by the frame delta coefficients unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fdc_pkg;

	localparam int COEFF_W     = 16;
	localparam int DELTA_W     = 17;
	localparam int INDEX_W     = 4;
	localparam int CFG_W       = 5;
	localparam int SLOT_W      = 3;
	localparam int RING_FRAMES = 5;
	localparam int EDGE        = 2;

	typedef logic signed [COEFF_W-1:0] coeff_t;
	typedef logic signed [DELTA_W-1:0] delta_t;
	typedef logic [INDEX_W-1:0]        index_t;
	typedef logic [CFG_W-1:0]          cfg_t;
	typedef logic [SLOT_W-1:0]         slot_t;

	localparam cfg_t  CFG_RESET  = cfg_t'(13);
	localparam slot_t LAST_SLOT  = slot_t'(RING_FRAMES - 1);
	localparam slot_t SEEN_MAX   = slot_t'(7);

endpackage

`default_nettype wire

[hdl/fdc_coeff_if.sv]
// ----------------------------------------------------------------------------
// fdc_coeff_if
// Valid/ready channel that carries one feature coefficient per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface fdc_coeff_if
	import fdc_pkg::*;
();
	logic   valid;
	logic   ready;
	coeff_t coeff_value;
	logic   final_frame;

	modport source (output valid, output coeff_value, output final_frame, input ready);
	modport sink   (input valid, input coeff_value, input final_frame, output ready);
endinterface

`default_nettype wire

[hdl/fdc_delta_if.sv]
// ----------------------------------------------------------------------------
// fdc_delta_if
// Valid/ready channel that carries one delta coefficient per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface fdc_delta_if
	import fdc_pkg::*;
();
	logic   valid;
	logic   ready;
	delta_t delta_value;
	index_t coeff_index;
	logic   utterance_end;

	modport source (output valid, output delta_value, output coeff_index,
		output utterance_end, input ready);
	modport sink   (input valid, input delta_value, input coeff_index,
		input utterance_end, output ready);
endinterface

`default_nettype wire

[hdl/frame_delta_coefficients_unit.sv]
// ----------------------------------------------------------------------------
// frame_delta_coefficients_unit: delta of a feature stream over a 5-frame ring.
// Takes one coefficient word per cycle unless stalled; a delta word passes a read
// stage and an output register. The last word of an utterance holds off input for 2*N
// flush deltas, or N for a one-frame utterance (N coefficients in use), one per cycle
// unless stalled, both ring reads in the same cycle. Reset clears counters, ring unset.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_delta_coefficients_unit
	import fdc_pkg::*;
#(
	parameter int MAX_COEFFS = 16
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   cfg_wr_en,
	input  wire cfg_t   cfg_wr_data,
	fdc_coeff_if.sink   coeffs,
	fdc_delta_if.source deltas
);

	localparam int CNT_W      = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;
	localparam int RING_DEPTH = RING_FRAMES * MAX_COEFFS;
	localparam int ADDR_W     = $clog2(RING_DEPTH);
	localparam int CMP_W      = CFG_W + 1;
	localparam cfg_t MAX_N    = cfg_t'(MAX_COEFFS);

	localparam logic ST_STREAM = 1'b0;
	localparam logic ST_FLUSH  = 1'b1;

	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [ADDR_W-1:0] addr_t;

	function automatic addr_t ring_addr(input slot_t s, input cnt_t m);
		ring_addr = addr_t'(s) * addr_t'(MAX_COEFFS) + addr_t'(m);
	endfunction

	// Slot of the frame that lies min(limit, seen) frames behind the current one.
	function automatic slot_t back_slot(input slot_t s, input slot_t limit, input slot_t seen);
		slot_t back;
		back = (seen < limit) ? seen : limit;
		back_slot = (s >= back) ? slot_t'(s - back) : slot_t'(s + slot_t'(RING_FRAMES) - back);
	endfunction

	coeff_t ring_mem [RING_DEPTH];

	logic  state_q;
	cnt_t  cnt_q;
	slot_t slot_q;
	slot_t seen_q;
	cnt_t  fl_c_q;
	logic  fl_d_q;
	cfg_t  n_q;

	logic   valid_s1;
	logic   use_mem_s1;
	coeff_t x_s1;
	index_t index_s1;
	logic   end_s1;
	coeff_t rd_a_s1;
	coeff_t rd_b_s1;

	logic   out_v_q;
	delta_t out_delta_q;
	index_t out_index_q;
	logic   out_end_q;

	cfg_t   n_eff;
	logic   out_free;
	logic   s1_adv;
	logic   issue_ok;
	logic   acc;
	logic   last_c;
	logic   fl_last;
	logic   stream_emit;
	logic   flush_issue;
	logic   rd_en;
	addr_t  wr_addr;
	addr_t  rd_a_addr;
	addr_t  rd_b_addr;
	coeff_t fwd;
	delta_t delta;

	always_comb begin
		if (n_q == cfg_t'(0)) begin
			n_eff = cfg_t'(1);
		end else if (n_q > MAX_N) begin
			n_eff = MAX_N;
		end else begin
			n_eff = n_q;
		end
	end

	assign out_free = !out_v_q || deltas.ready;
	assign s1_adv   = valid_s1 && out_free;
	assign issue_ok = !valid_s1 || s1_adv;

	assign coeffs.ready = (state_q == ST_STREAM) && issue_ok;
	assign acc          = coeffs.valid && coeffs.ready;

	assign last_c  = ({1'b0, cfg_t'(cnt_q)} + CMP_W'(1)) >= {1'b0, n_eff};
	assign fl_last = ({1'b0, cfg_t'(fl_c_q)} + CMP_W'(1)) >= {1'b0, n_eff};

	assign stream_emit = acc && (seen_q >= slot_t'(EDGE));
	assign flush_issue = (state_q == ST_FLUSH) && issue_ok;
	assign rd_en       = stream_emit || flush_issue;

	assign wr_addr   = ring_addr(slot_q, cnt_q);
	assign rd_a_addr = ring_addr(slot_q, fl_c_q);

	always_comb begin
		if (state_q == ST_FLUSH) begin
			rd_b_addr = ring_addr(back_slot(slot_q, slot_t'(EDGE) + slot_t'(fl_d_q), seen_q),
				fl_c_q);
		end else begin
			rd_b_addr = ring_addr(back_slot(slot_q, slot_t'(2 * EDGE), seen_q), cnt_q);
		end
	end

	// Ring memory: one write port, two registered read ports. The streaming
	// read never hits the slot being written, so no forwarding is needed.
	always_ff @(posedge clk) begin
		if (acc) begin
			ring_mem[wr_addr] <= coeffs.coeff_value;
		end
		if (rd_en) begin
			rd_a_s1 <= ring_mem[rd_a_addr];
			rd_b_s1 <= ring_mem[rd_b_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			use_mem_s1 <= (state_q == ST_FLUSH);
			x_s1       <= coeffs.coeff_value;
			index_s1   <= (state_q == ST_FLUSH) ? index_t'(fl_c_q) : index_t'(cnt_q);
			end_s1     <= (state_q == ST_FLUSH) && !fl_d_q && fl_last;
		end
	end

	assign fwd   = use_mem_s1 ? rd_a_s1 : x_s1;
	assign delta = delta_t'(fwd) - delta_t'(rd_b_s1);

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_delta_q <= delta;
			out_index_q <= index_s1;
			out_end_q   <= end_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (rd_en) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_v_q <= 1'b1;
			end else if (deltas.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= CFG_RESET;
		end else if (cfg_wr_en) begin
			n_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_STREAM;
			cnt_q   <= '0;
			slot_q  <= '0;
			seen_q  <= '0;
			fl_c_q  <= '0;
			fl_d_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_STREAM: begin
					if (acc) begin
						if (!last_c) begin
							cnt_q <= cnt_t'(cnt_q + cnt_t'(1));
						end else if (coeffs.final_frame) begin
							// Keep slot and frame count: the flush reads back through them.
							state_q <= ST_FLUSH;
							cnt_q   <= '0;
							fl_c_q  <= '0;
							fl_d_q  <= (seen_q != slot_t'(0));
						end else begin
							cnt_q  <= '0;
							slot_q <= (slot_q == LAST_SLOT) ? slot_t'(0) : slot_t'(slot_q + slot_t'(1));
							if (seen_q != SEEN_MAX) begin
								seen_q <= slot_t'(seen_q + slot_t'(1));
							end
						end
					end
				end
				ST_FLUSH: begin
					if (flush_issue) begin
						if (!fl_last) begin
							fl_c_q <= cnt_t'(fl_c_q + cnt_t'(1));
						end else if (fl_d_q) begin
							fl_d_q <= 1'b0;
							fl_c_q <= '0;
						end else begin
							state_q <= ST_STREAM;
							seen_q  <= '0;
							slot_q  <= '0;
							cnt_q   <= '0;
						end
					end
				end
				default: begin
					state_q <= ST_STREAM;
				end
			endcase
		end
	end

	assign deltas.valid         = out_v_q;
	assign deltas.delta_value   = out_delta_q;
	assign deltas.coeff_index   = out_index_q;
	assign deltas.utterance_end = out_end_q;

endmodule

`default_nettype wire
